// ===== sv/lgg_pkg.sv =====
// ----------------------------------------------------------------------------
// lgg_pkg
// Shared types, opcodes and sizes for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgg_pkg;

	// grid size
	localparam int ROWS = 64;
	localparam int COLS = 128;

	// fixed field widths of the transaction payloads
	localparam int OP_W  = 3;
	localparam int ROW_W = 6;
	localparam int COL_W = 7;
	localparam int POP_W = 14;
	localparam int GEN_W = 32;

	localparam int POP_MAX = (1 << POP_W) - 1;

	// derived sizes
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CNT_W  = $clog2(ROWS * COLS + 1);
	localparam int K_W    = $clog2(ROWS + 2);

	// population is counted in lanes of eight cells per row
	localparam int LANE_W = 8;
	localparam int NLANE  = (COLS + LANE_W - 1) / LANE_W;
	localparam int LCNT_W = $clog2(LANE_W + 1);

	// opcodes
	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_SET   = 3'd1;
	localparam logic [OP_W-1:0] OP_KILL  = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_STEP  = 3'd4;

	typedef logic [COLS-1:0] row_t;
	typedef logic [NLANE-1:0][LCNT_W-1:0] lane_cnt_t;

	// three-row neighborhood handed to the rule logic
	typedef struct packed {
		row_t above;
		row_t cur;
		row_t below;
	} window_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} in_item_t;

	typedef struct packed {
		logic             cell_alive;
		logic [POP_W-1:0] population;
		logic [GEN_W-1:0] generation;
	} out_item_t;

endpackage

// ===== sv/life_grid_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded B3/S23 cellular grid with cell edits, clear and generation step.
// ----------------------------------------------------------------------------
// The grid lives in a row-wide RAM (one row per entry, one read and one write
// port) with a per-row valid bit that makes reset and clear instant: a row
// that was never written since reset or the last clear reads as all dead.
// One transaction is worked on at a time and every transaction returns one
// result. Read, set and kill go through a RAM read, then a read-modify-write
// (ST_LOOK), then ST_DONE, which loads the result register once the output
// is free; clear goes straight to ST_DONE. A step sweeps the RAM once, one
// row read and one row written per cycle with a three-row window, then
// drains the population adder pipeline and ends with a final read of the
// addressed cell. in_ready is high whenever no transaction is in flight,
// so a new transaction is taken while the previous result still waits on
// out_ready.
module life_grid_generation_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lgg_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output lgg_pkg::out_item_t out_item
);
	import lgg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SWEEP  = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_RDBACK = 6'b001000,
		ST_LOOK   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	// transaction being worked on
	logic [OP_W-1:0]  op_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             cell_q;

	// architectural state besides the grid
	logic [ROWS-1:0]  row_vld_q;   // row written since reset / clear
	logic [CNT_W-1:0] live_q;
	logic [GEN_W-1:0] gen_q;

	// sweep: row counter, window, population pipeline
	logic [K_W-1:0]   k_q;
	row_t             above_q;
	row_t             cur_q;
	lane_cnt_t        pc_s1;
	logic             pcv_s1;
	logic [CNT_W-1:0] acc_q;

	// RAM ports
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	row_t              ram_wdata;
	logic              ram_re;
	logic [ROW_AW-1:0] ram_raddr;
	row_t              ram_rdata;
	logic              rd_ok_s1;   // read last cycle hit a valid row

	logic             out_valid_q;
	out_item_t        out_item_q;

	logic              accept;
	logic              out_free;
	row_t              mem_row;
	row_t              wr_row;
	row_t              nxt_row;
	lane_cnt_t         lane_cnt;
	window_t           win;
	logic [COL_AW-1:0] cidx;
	logic [ROW_AW-1:0] raddr_q;
	logic              on_grid;
	logic              is_edit;
	logic              want;
	logic              look_bit;
	logic              sweep_wr;
	logic [CNT_W-1:0]  lane_sum;
	logic [POP_W-1:0]  pop_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// unwritten rows read as dead
	assign mem_row  = rd_ok_s1 ? ram_rdata : '0;
	assign cidx     = COL_AW'(col_q);
	assign raddr_q  = ROW_AW'(row_q);
	assign on_grid  = (int'(row_q) < ROWS) && (int'(col_q) < COLS);
	assign is_edit  = (op_q == OP_SET) || (op_q == OP_KILL);
	assign want     = (op_q == OP_SET);
	assign look_bit = mem_row[cidx];
	assign sweep_wr = (state_q == ST_SWEEP) && (k_q >= K_W'(2));

	always_comb begin
		wr_row       = mem_row;
		wr_row[cidx] = want;
	end

	// window for row k-2: the two rows held back plus the one just read
	assign win.above = above_q;
	assign win.cur   = cur_q;
	assign win.below = mem_row;

	lgg_row_rule u_rule (
		.win      (win),
		.nxt      (nxt_row),
		.lane_cnt (lane_cnt)
	);

	lgg_row_ram #(
		.DEPTH (ROWS),
		.WIDTH (COLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM port steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = nxt_row;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_item.opcode != OP_CLEAR) && (in_item.opcode != OP_STEP)) begin
					ram_re    = 1'b1;
					ram_raddr = ROW_AW'(in_item.row);
				end
			end
			ST_SWEEP: begin
				// read row k, write back row k-2; never the same entry
				if (int'(k_q) < ROWS) begin
					ram_re    = 1'b1;
					ram_raddr = ROW_AW'(k_q);
				end
				if (sweep_wr) begin
					ram_we    = 1'b1;
					ram_waddr = ROW_AW'(k_q - K_W'(2));
				end
			end
			ST_RDBACK: begin
				ram_re    = 1'b1;
				ram_raddr = raddr_q;
			end
			ST_LOOK: begin
				if (is_edit && on_grid) begin
					ram_we    = 1'b1;
					ram_waddr = raddr_q;
					ram_wdata = wr_row;
				end
			end
			ST_DRAIN, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sum of the lane counts of one finished row
	always_comb begin
		lane_sum = '0;
		for (int l = 0; l < NLANE; l++) begin
			lane_sum = lane_sum + CNT_W'(pc_s1[l]);
		end
	end

	assign pop_sat = (int'(live_q) > POP_MAX) ? POP_W'(POP_MAX) : POP_W'(live_q);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rd_ok_s1    <= 1'b0;
			pcv_s1      <= 1'b0;
			row_vld_q   <= '0;
			live_q      <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_ok_s1 <= ram_re && (int'(ram_raddr) < ROWS) && row_vld_q[ram_raddr];
			pcv_s1   <= sweep_wr;
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			// in ST_DONE the next result takes over the output register
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.opcode == OP_CLEAR) begin
							row_vld_q <= '0;
							live_q    <= '0;
							gen_q     <= '0;
							state_q   <= ST_DONE;
						end else if (in_item.opcode == OP_STEP) begin
							k_q     <= '0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_SWEEP: begin
					if (k_q == K_W'(ROWS + 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RDBACK;
				end
				ST_RDBACK: begin
					live_q  <= acc_q;
					gen_q   <= gen_q + GEN_W'(1);
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (is_edit) begin
						gen_q <= '0;
						if (on_grid && (look_bit != want)) begin
							live_q <= want ? live_q + CNT_W'(1) : live_q - CNT_W'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		pc_s1 <= lane_cnt;
		if (accept) begin
			op_q   <= in_item.opcode;
			row_q  <= in_item.row;
			col_q  <= in_item.col;
			cell_q <= 1'b0;   // clear leaves every cell dead
		end
		if (state_q == ST_SWEEP) begin
			if (k_q == '0) begin
				above_q <= '0;
				cur_q   <= '0;
			end else begin
				above_q <= cur_q;
				cur_q   <= mem_row;
			end
		end
		if ((state_q == ST_SWEEP) && (k_q == '0)) begin
			acc_q <= '0;
		end else if (pcv_s1) begin
			acc_q <= acc_q + lane_sum;
		end
		if (state_q == ST_LOOK) begin
			cell_q <= on_grid && (is_edit ? want : look_bit);
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_item_q.cell_alive <= cell_q;
			out_item_q.population <= pop_sat;
			out_item_q.generation <= gen_q;
		end
	end

endmodule

// ===== sv/lgg_row_ram.sv =====
// ----------------------------------------------------------------------------
// lgg_row_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lgg_row_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/lgg_row_rule.sv =====
// ----------------------------------------------------------------------------
// lgg_row_rule
// B3/S23 next state for one row from its three-row window, plus lane counts.
// ----------------------------------------------------------------------------
module lgg_row_rule (
	input  lgg_pkg::window_t   win,
	output lgg_pkg::row_t      nxt,
	output lgg_pkg::lane_cnt_t lane_cnt
);
	import lgg_pkg::*;

	logic [COLS+1:0]         ext_a;
	logic [COLS+1:0]         ext_c;
	logic [COLS+1:0]         ext_b;
	logic [NLANE*LANE_W-1:0] pad;

	// zero columns on both sides: no wrap at the edges
	assign ext_a = {1'b0, win.above, 1'b0};
	assign ext_c = {1'b0, win.cur,   1'b0};
	assign ext_b = {1'b0, win.below, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < COLS; c++) begin
			n = 4'(ext_a[c]) + 4'(ext_a[c+1]) + 4'(ext_a[c+2])
			  + 4'(ext_c[c])                  + 4'(ext_c[c+2])
			  + 4'(ext_b[c]) + 4'(ext_b[c+1]) + 4'(ext_b[c+2]);
			nxt[c] = (n == 4'd3) || (win.cur[c] && (n == 4'd2));
		end
	end

	assign pad = (NLANE*LANE_W)'(nxt);

	always_comb begin
		logic [LCNT_W-1:0] s;
		for (int l = 0; l < NLANE; l++) begin
			s = '0;
			for (int j = 0; j < LANE_W; j++) begin
				s = s + LCNT_W'(pad[l*LANE_W + j]);
			end
			lane_cnt[l] = s;
		end
	end

endmodule

// ===== sv/lgg_checker.sv =====
// ----------------------------------------------------------------------------
// lgg_checker
// Port-level assertions for life_grid_generation_step, bound to the top level.
// ----------------------------------------------------------------------------
module lgg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input lgg_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input lgg_pkg::out_item_t out_item
);
	import lgg_pkg::*;

	// one transaction in flight: the next result belongs to the last accept
	logic [OP_W-1:0]  last_op_q;
	logic [ROW_W-1:0] last_row_q;
	logic [COL_W-1:0] last_col_q;
	logic             last_on_grid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_op_q  <= OP_READ;
			last_row_q <= '0;
			last_col_q <= '0;
		end else if (in_valid && in_ready) begin
			last_op_q  <= in_item.opcode;
			last_row_q <= in_item.row;
			last_col_q <= in_item.col;
		end
	end

	assign last_on_grid = (int'(last_row_q) < ROWS) && (int'(last_col_q) < COLS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && (last_op_q == OP_CLEAR) |->
			!out_item.cell_alive && (out_item.population == '0) && (out_item.generation == '0))
		else $error("clear did not empty the grid");

	a_edit_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && ((last_op_q == OP_SET) || (last_op_q == OP_KILL)) |->
			(out_item.generation == '0) &&
			(out_item.cell_alive == (last_on_grid && (last_op_q == OP_SET))))
		else $error("set or kill result wrong");

endmodule

bind life_grid_generation_step lgg_checker u_lgg_checker (.*);
